// ===== hw/rtl/ajps_pkg.sv =====
// shared types, constants and helper functions for the arm jog and pose sequencer
package ajps_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_DEAD_ZONE     = 2'd0;
	localparam logic [1:0] CFG_POSE_INTERVAL = 2'd1;
	localparam logic [1:0] CFG_GRIP_STEP     = 2'd2;

	// configuration reset values
	localparam logic [6:0]  DEAD_ZONE_RST     = 7'd10;
	localparam logic [15:0] POSE_INTERVAL_RST = 16'd400;
	localparam logic [3:0]  GRIP_STEP_RST     = 4'd2;

	// button bit positions
	localparam int BTN_GRAB = 0;
	localparam int BTN_OPEN = 1;
	localparam int BTN_PICK = 2;
	localparam int BTN_DROP = 3;
	localparam int BTN_STOP = 4;

	// h-bridge direction codes
	localparam logic [3:0] BRIDGE_OFF   = 4'h0;
	localparam logic [3:0] BRIDGE_FWD   = 4'h5;
	localparam logic [3:0] BRIDGE_BACK  = 4'hA;
	localparam logic [3:0] BRIDGE_RIGHT = 4'h9;
	localparam logic [3:0] BRIDGE_LEFT  = 4'h6;

	localparam logic signed [7:0] DRIVE_THRESH = 8'sd20;
	localparam logic [6:0] SLIDER_MAX = 7'd100;
	localparam logic [9:0] DUTY_BASE  = 10'd80;

	// joint limits and reset positions
	localparam logic [7:0] JOINT_RST    = 8'd90;
	localparam logic [6:0] GRIP_RST     = 7'd30;
	localparam logic [7:0] BASE_MAX     = 8'd180;
	localparam logic [7:0] SHOULDER_MIN = 8'd30;
	localparam logic [7:0] SHOULDER_MAX = 8'd150;
	localparam logic [7:0] ELBOW_MAX    = 8'd170;
	localparam logic [7:0] WRIST_MAX    = 8'd180;
	localparam logic [7:0] GRIP_MIN     = 8'd30;
	localparam logic [7:0] GRIP_MAX     = 8'd120;
	localparam logic [7:0] ANGLE_MIN    = 8'd0;

	// sequence poses
	localparam logic signed [9:0] PICK0_SHOULDER = 10'sd120;
	localparam logic signed [9:0] PICK0_ELBOW    = 10'sd60;
	localparam logic signed [9:0] PICK0_WRIST    = 10'sd80;
	localparam logic signed [9:0] PICK1_SHOULDER = 10'sd140;
	localparam logic signed [9:0] PICK1_ELBOW    = 10'sd40;
	localparam logic signed [9:0] GRIP_CLOSED    = 10'sd120;
	localparam logic signed [9:0] GRIP_OPENED    = 10'sd30;
	localparam logic signed [9:0] HOME_ANGLE     = 10'sd90;
	localparam logic signed [9:0] DROP0_SHOULDER = 10'sd110;
	localparam logic signed [9:0] DROP0_ELBOW    = 10'sd60;
	localparam logic signed [9:0] DROP0_WRIST    = 10'sd70;

	typedef struct packed {
		logic signed [7:0] drive_front_back;
		logic signed [7:0] drive_left_right;
		logic signed [7:0] base_stick;
		logic signed [7:0] shoulder_stick;
		logic signed [7:0] elbow_stick;
		logic signed [7:0] wrist_stick;
		logic [4:0]        buttons;
		logic [6:0]        speed_slider;
		logic [31:0]       now_ms;
	} frame_t;

	typedef struct packed {
		logic [7:0] base_angle;
		logic [7:0] shoulder_angle;
		logic [7:0] elbow_angle;
		logic [7:0] wrist_angle;
		logic [6:0] grip_angle;
		logic [3:0] bridge_bits;
		logic [7:0] drive_duty;
		logic       pick_busy;
		logic       drop_busy;
	} result_t;

	typedef struct packed {
		logic [6:0]  dead_zone;
		logic [15:0] pose_interval_ms;
		logic [3:0]  grip_step;
	} cfg_t;

	// joint jog amount: stick/20 toward zero, zero inside the dead zone
	function automatic logic signed [3:0] jog_delta(input logic signed [7:0] stick,
			input logic [6:0] dz);
		logic [7:0] u;
		logic [7:0] mag;
		logic [2:0] q;
		logic signed [3:0] d;
		u = stick;
		mag = stick[7] ? (~u + 8'd1) : u;
		if (mag >= 8'd120) q = 3'd6;
		else if (mag >= 8'd100) q = 3'd5;
		else if (mag >= 8'd80) q = 3'd4;
		else if (mag >= 8'd60) q = 3'd3;
		else if (mag >= 8'd40) q = 3'd2;
		else if (mag >= 8'd20) q = 3'd1;
		else q = 3'd0;
		d = stick[7] ? -signed'({1'b0, q}) : signed'({1'b0, q});
		if (mag <= {1'b0, dz}) d = 4'sd0;
		return d;
	endfunction

	// clamp a working angle into lo..hi
	function automatic logic [7:0] clamp_angle(input logic signed [9:0] v,
			input logic [7:0] lo, input logic [7:0] hi);
		logic [7:0] r;
		if (v < signed'({2'b00, lo})) r = lo;
		else if (v > signed'({2'b00, hi})) r = hi;
		else r = v[7:0];
		return r;
	endfunction

endpackage

// ===== hw/rtl/ajps_if.sv =====
// frame and result channel interfaces with valid/ready handshake

interface ajps_frame_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] drive_front_back;
	logic signed [7:0] drive_left_right;
	logic signed [7:0] base_stick;
	logic signed [7:0] shoulder_stick;
	logic signed [7:0] elbow_stick;
	logic signed [7:0] wrist_stick;
	logic [4:0]        buttons;
	logic [6:0]        speed_slider;
	logic [31:0]       now_ms;

	modport source (output valid, drive_front_back, drive_left_right, base_stick,
		shoulder_stick, elbow_stick, wrist_stick, buttons, speed_slider, now_ms,
		input ready);
	modport sink (input valid, drive_front_back, drive_left_right, base_stick,
		shoulder_stick, elbow_stick, wrist_stick, buttons, speed_slider, now_ms,
		output ready);
endinterface

interface ajps_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] base_angle;
	logic [7:0] shoulder_angle;
	logic [7:0] elbow_angle;
	logic [7:0] wrist_angle;
	logic [6:0] grip_angle;
	logic [3:0] bridge_bits;
	logic [7:0] drive_duty;
	logic       pick_busy;
	logic       drop_busy;

	modport source (output valid, base_angle, shoulder_angle, elbow_angle, wrist_angle,
		grip_angle, bridge_bits, drive_duty, pick_busy, drop_busy, input ready);
	modport sink (input valid, base_angle, shoulder_angle, elbow_angle, wrist_angle,
		grip_angle, bridge_bits, drive_duty, pick_busy, drop_busy, output ready);
endinterface

// ===== hw/rtl/ajps_cfg.sv =====
// configuration register file: dead zone, pose interval, grip step
module ajps_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_wdata,
	output ajps_pkg::cfg_t    cfg
);

	ajps_pkg::cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_zone        <= ajps_pkg::DEAD_ZONE_RST;
			cfg_q.pose_interval_ms <= ajps_pkg::POSE_INTERVAL_RST;
			cfg_q.grip_step        <= ajps_pkg::GRIP_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ajps_pkg::CFG_DEAD_ZONE:     cfg_q.dead_zone        <= cfg_wdata[6:0];
				ajps_pkg::CFG_POSE_INTERVAL: cfg_q.pose_interval_ms <= cfg_wdata;
				ajps_pkg::CFG_GRIP_STEP:     cfg_q.grip_step        <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/ajps_core.sv =====
// arm state registers and the single-pass step logic for one frame
module ajps_core #(
	parameter int TIME_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step_en,
	input  ajps_pkg::frame_t   frame_s1,
	input  ajps_pkg::cfg_t     cfg,
	output ajps_pkg::result_t  res_next
);

	// arm and sequence state
	logic [7:0]           base_q, shoulder_q, elbow_q, wrist_q;
	logic [6:0]           grip_q;
	logic                 pick_q, drop_q;
	logic [1:0]           idx_q;
	logic [TIME_BITS-1:0] start_q;
	logic [7:0]           held_duty_q;

	// working values for this frame
	logic signed [9:0]    base_w, sh_w, el_w, wr_w, gr_w;
	logic                 pick_w, drop_w;
	logic [1:0]           idx_w;
	logic [TIME_BITS-1:0] start_w;
	logic [3:0]           bits_w;
	logic [7:0]           duty_w;
	logic [6:0]           slider_w;
	logic [9:0]           slider_x7;
	logic [63:0]          now_ext;
	logic [TIME_BITS-1:0] now_w;
	logic [TIME_BITS-1:0] ivl_w;
	logic [7:0]           base_c, sh_c, el_c, wr_c, gr_c;

	assign now_ext   = {32'd0, frame_s1.now_ms};
	assign now_w     = now_ext[TIME_BITS-1:0];
	assign ivl_w     = TIME_BITS'(cfg.pose_interval_ms);
	assign slider_w  = (frame_s1.speed_slider > ajps_pkg::SLIDER_MAX) ?
		ajps_pkg::SLIDER_MAX : frame_s1.speed_slider;
	// slider*175/100 is exactly 7*slider/4
	assign slider_x7 = ({3'd0, slider_w} << 3) - {3'd0, slider_w};

	// drive decode, jog, gripper and pose sequencing
	always_comb begin
		bits_w = ajps_pkg::BRIDGE_OFF;
		duty_w = held_duty_q;
		if (!frame_s1.buttons[ajps_pkg::BTN_STOP]) begin
			if (frame_s1.drive_front_back > ajps_pkg::DRIVE_THRESH)
				bits_w = ajps_pkg::BRIDGE_FWD;
			else if (frame_s1.drive_front_back < -ajps_pkg::DRIVE_THRESH)
				bits_w = ajps_pkg::BRIDGE_BACK;
			else if (frame_s1.drive_left_right > ajps_pkg::DRIVE_THRESH)
				bits_w = ajps_pkg::BRIDGE_RIGHT;
			else if (frame_s1.drive_left_right < -ajps_pkg::DRIVE_THRESH)
				bits_w = ajps_pkg::BRIDGE_LEFT;
			duty_w = 8'(ajps_pkg::DUTY_BASE + (slider_x7 >> 2));
		end

		base_w = signed'({2'b00, base_q})
			+ 10'(ajps_pkg::jog_delta(frame_s1.base_stick, cfg.dead_zone));
		sh_w   = signed'({2'b00, shoulder_q})
			+ 10'(ajps_pkg::jog_delta(frame_s1.shoulder_stick, cfg.dead_zone));
		el_w   = signed'({2'b00, elbow_q})
			+ 10'(ajps_pkg::jog_delta(frame_s1.elbow_stick, cfg.dead_zone));
		wr_w   = signed'({2'b00, wrist_q})
			+ 10'(ajps_pkg::jog_delta(frame_s1.wrist_stick, cfg.dead_zone));

		gr_w = signed'({3'b000, grip_q});
		if (frame_s1.buttons[ajps_pkg::BTN_GRAB])
			gr_w = gr_w + signed'({6'd0, cfg.grip_step});
		if (frame_s1.buttons[ajps_pkg::BTN_OPEN])
			gr_w = gr_w - signed'({6'd0, cfg.grip_step});

		pick_w  = pick_q;
		drop_w  = drop_q;
		idx_w   = idx_q;
		start_w = start_q;

		// sequence start; drop wins when both are pressed
		if (frame_s1.buttons[ajps_pkg::BTN_PICK] && !pick_w) begin
			pick_w  = 1'b1;
			drop_w  = 1'b0;
			idx_w   = 2'd0;
			start_w = now_w;
		end
		if (frame_s1.buttons[ajps_pkg::BTN_DROP] && !drop_w) begin
			drop_w  = 1'b1;
			pick_w  = 1'b0;
			idx_w   = 2'd0;
			start_w = now_w;
		end

		// pick poses
		if (pick_w && ((now_w - start_w) >= ivl_w)) begin
			start_w = now_w;
			case (idx_w)
				2'd0: begin
					sh_w = ajps_pkg::PICK0_SHOULDER;
					el_w = ajps_pkg::PICK0_ELBOW;
					wr_w = ajps_pkg::PICK0_WRIST;
				end
				2'd1: begin
					sh_w = ajps_pkg::PICK1_SHOULDER;
					el_w = ajps_pkg::PICK1_ELBOW;
				end
				2'd2: gr_w = ajps_pkg::GRIP_CLOSED;
				default: begin
					sh_w   = ajps_pkg::HOME_ANGLE;
					el_w   = ajps_pkg::HOME_ANGLE;
					pick_w = 1'b0;
				end
			endcase
			idx_w = idx_w + 2'd1;
		end

		// drop poses
		if (drop_w && ((now_w - start_w) >= ivl_w)) begin
			start_w = now_w;
			case (idx_w)
				2'd0: begin
					sh_w  = ajps_pkg::DROP0_SHOULDER;
					el_w  = ajps_pkg::DROP0_ELBOW;
					wr_w  = ajps_pkg::DROP0_WRIST;
					idx_w = 2'd1;
				end
				2'd1: begin
					gr_w  = ajps_pkg::GRIP_OPENED;
					idx_w = 2'd2;
				end
				2'd2: begin
					sh_w   = ajps_pkg::HOME_ANGLE;
					el_w   = ajps_pkg::HOME_ANGLE;
					drop_w = 1'b0;
					idx_w  = 2'd0;
				end
				default: idx_w = 2'd0;
			endcase
		end
	end

	// joint limits
	assign base_c = ajps_pkg::clamp_angle(base_w, ajps_pkg::ANGLE_MIN, ajps_pkg::BASE_MAX);
	assign sh_c   = ajps_pkg::clamp_angle(sh_w, ajps_pkg::SHOULDER_MIN,
		ajps_pkg::SHOULDER_MAX);
	assign el_c   = ajps_pkg::clamp_angle(el_w, ajps_pkg::ANGLE_MIN, ajps_pkg::ELBOW_MAX);
	assign wr_c   = ajps_pkg::clamp_angle(wr_w, ajps_pkg::ANGLE_MIN, ajps_pkg::WRIST_MAX);
	assign gr_c   = ajps_pkg::clamp_angle(gr_w, ajps_pkg::GRIP_MIN, ajps_pkg::GRIP_MAX);

	always_comb begin
		res_next.base_angle     = base_c;
		res_next.shoulder_angle = sh_c;
		res_next.elbow_angle    = el_c;
		res_next.wrist_angle    = wr_c;
		res_next.grip_angle     = gr_c[6:0];
		res_next.bridge_bits    = bits_w;
		res_next.drive_duty     = duty_w;
		res_next.pick_busy      = pick_w;
		res_next.drop_busy      = drop_w;
	end

	// state update once per frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= ajps_pkg::JOINT_RST;
			shoulder_q  <= ajps_pkg::JOINT_RST;
			elbow_q     <= ajps_pkg::JOINT_RST;
			wrist_q     <= ajps_pkg::JOINT_RST;
			grip_q      <= ajps_pkg::GRIP_RST;
			pick_q      <= 1'b0;
			drop_q      <= 1'b0;
			idx_q       <= 2'd0;
			start_q     <= '0;
			held_duty_q <= 8'd0;
		end else if (step_en) begin
			base_q      <= base_c;
			shoulder_q  <= sh_c;
			elbow_q     <= el_c;
			wrist_q     <= wr_c;
			grip_q      <= gr_c[6:0];
			pick_q      <= pick_w;
			drop_q      <= drop_w;
			idx_q       <= idx_w;
			start_q     <= start_w;
			held_duty_q <= duty_w;
		end
	end

endmodule

// ===== hw/rtl/arm_jog_and_pose_sequencer_top.sv =====
// Arm jog and pose sequencer: one remote-control frame in, one servo/drive result out.
// A frame is registered on acceptance, processed in a single pass against the arm
// state, and its result is held in an output register; a frame passes the input register
// and then the output register, and one frame is taken every clock while the result port
// takes each result, set by the state registers updating as each result is registered.
// The frame port keeps accepting while a result waits, up to one frame in the input
// register. Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) with no
// read-back; write it only while no frame is in flight.
module arm_jog_and_pose_sequencer_top #(
	parameter int TIME_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	ajps_frame_if.sink           frame,
	ajps_result_if.source        result,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_wdata
);

	ajps_pkg::cfg_t    cfg;
	ajps_pkg::frame_t  frame_s1;
	logic              valid_s1;
	ajps_pkg::result_t res_next;
	ajps_pkg::result_t res_q;
	logic              res_valid_q;
	logic              advance;
	logic              take;

	ajps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ajps_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (advance),
		.frame_s1 (frame_s1),
		.cfg      (cfg),
		.res_next (res_next)
	);

	// pipeline handshake
	assign advance     = valid_s1 && (!res_valid_q || result.ready);
	assign frame.ready = !valid_s1 || advance;
	assign take        = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	// input and result payload registers
	always_ff @(posedge clk) begin
		if (take) begin
			frame_s1.drive_front_back <= frame.drive_front_back;
			frame_s1.drive_left_right <= frame.drive_left_right;
			frame_s1.base_stick       <= frame.base_stick;
			frame_s1.shoulder_stick   <= frame.shoulder_stick;
			frame_s1.elbow_stick      <= frame.elbow_stick;
			frame_s1.wrist_stick      <= frame.wrist_stick;
			frame_s1.buttons          <= frame.buttons;
			frame_s1.speed_slider     <= frame.speed_slider;
			frame_s1.now_ms           <= frame.now_ms;
		end
		if (advance)
			res_q <= res_next;
	end

	assign result.valid          = res_valid_q;
	assign result.base_angle     = res_q.base_angle;
	assign result.shoulder_angle = res_q.shoulder_angle;
	assign result.elbow_angle    = res_q.elbow_angle;
	assign result.wrist_angle    = res_q.wrist_angle;
	assign result.grip_angle     = res_q.grip_angle;
	assign result.bridge_bits    = res_q.bridge_bits;
	assign result.drive_duty     = res_q.drive_duty;
	assign result.pick_busy      = res_q.pick_busy;
	assign result.drop_busy      = res_q.drop_busy;

endmodule

// ===== hw/rtl/ajps_checker.sv =====
// port-level checks for the arm jog and pose sequencer, bound to the top level
module ajps_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] base_angle,
	input logic [7:0] shoulder_angle,
	input logic [7:0] elbow_angle,
	input logic [7:0] wrist_angle,
	input logic [6:0] grip_angle,
	input logic [3:0] bridge_bits,
	input logic       pick_busy,
	input logic       drop_busy
);

	// a stalled result stays valid and its shoulder, grip and bridge fields hold
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(shoulder_angle)
			&& $stable(grip_angle) && $stable(bridge_bits))
		else $error("stalled result changed");

	// only one direction code at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bridge_bits == ajps_pkg::BRIDGE_OFF
			|| bridge_bits == ajps_pkg::BRIDGE_FWD || bridge_bits == ajps_pkg::BRIDGE_BACK
			|| bridge_bits == ajps_pkg::BRIDGE_RIGHT || bridge_bits == ajps_pkg::BRIDGE_LEFT))
		else $error("bad bridge code");

	// pick and drop sequences exclude each other
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(pick_busy && drop_busy))
		else $error("pick and drop both busy");

	// all joints inside their limits
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> base_angle <= ajps_pkg::BASE_MAX
			&& shoulder_angle >= ajps_pkg::SHOULDER_MIN
			&& shoulder_angle <= ajps_pkg::SHOULDER_MAX
			&& elbow_angle <= ajps_pkg::ELBOW_MAX && wrist_angle <= ajps_pkg::WRIST_MAX
			&& {1'b0, grip_angle} >= ajps_pkg::GRIP_MIN
			&& {1'b0, grip_angle} <= ajps_pkg::GRIP_MAX)
		else $error("joint out of range");

endmodule

bind arm_jog_and_pose_sequencer_top ajps_checker u_ajps_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.base_angle     (result.base_angle),
	.shoulder_angle (result.shoulder_angle),
	.elbow_angle    (result.elbow_angle),
	.wrist_angle    (result.wrist_angle),
	.grip_angle     (result.grip_angle),
	.bridge_bits    (result.bridge_bits),
	.pick_busy      (result.pick_busy),
	.drop_busy      (result.drop_busy)
);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the arm jog and pose sequencer: directed and random frames
module tb;

	localparam logic [4:0] BTN_GRAB_M = 5'(1 << ajps_pkg::BTN_GRAB);
	localparam logic [4:0] BTN_OPEN_M = 5'(1 << ajps_pkg::BTN_OPEN);
	localparam logic [4:0] BTN_PICK_M = 5'(1 << ajps_pkg::BTN_PICK);
	localparam logic [4:0] BTN_DROP_M = 5'(1 << ajps_pkg::BTN_DROP);
	localparam logic [4:0] BTN_STOP_M = 5'(1 << ajps_pkg::BTN_STOP);

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	ajps_frame_if  frame_ch ();
	ajps_result_if result_ch ();

	arm_jog_and_pose_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	// arm state mirror and register copies
	int          arm_base = 90, arm_shoulder = 90, arm_elbow = 90, arm_wrist = 90;
	int          arm_grip = 30;
	bit          pick_on = 1'b0, drop_on = 1'b0;
	logic [1:0]  pose_step = 2'd0;
	logic [31:0] pose_t0 = 32'd0;
	logic [7:0]  duty_hold = 8'd0;
	logic [6:0]  dz_cfg = 7'd10;
	logic [15:0] interval_cfg = 16'd400;
	logic [3:0]  grip_step_cfg = 4'd2;

	ajps_pkg::frame_t  frames_to_send[$];
	ajps_pkg::result_t expected_servo_out[$];
	ajps_pkg::frame_t  on_bus;
	int      frames_queued = 0;
	int      frames_accepted = 0;
	int      fail_count = 0;
	int      send_idle_pct = 7;
	int      recv_idle_pct = 47;
	logic [31:0] sim_ms = 32'd0;

	function automatic int clamp_int(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int jogged(int pos, logic signed [7:0] stick);
		int s;
		int mag;
		s = stick;
		mag = (s < 0) ? -s : s;
		if (mag > int'(dz_cfg))
			return pos + s / 20;
		return pos;
	endfunction

	function automatic bit pose_due(logic [31:0] now);
		logic [31:0] diff;
		diff = now - pose_t0;
		return diff >= {16'd0, interval_cfg};
	endfunction

	// advance the arm mirror by one frame and return the servo/drive outputs
	function automatic ajps_pkg::result_t next_servo_result(ajps_pkg::frame_t f);
		int                fb;
		int                lr;
		int                slider;
		logic [3:0]        bits;
		ajps_pkg::result_t r;
		fb = f.drive_front_back;
		lr = f.drive_left_right;
		slider = (f.speed_slider > 7'd100) ? 100 : int'(f.speed_slider);

		// drive bridge and duty
		if (f.buttons & BTN_STOP_M) begin
			bits = ajps_pkg::BRIDGE_OFF;
		end else begin
			if (fb > 20) bits = ajps_pkg::BRIDGE_FWD;
			else if (fb < -20) bits = ajps_pkg::BRIDGE_BACK;
			else if (lr > 20) bits = ajps_pkg::BRIDGE_RIGHT;
			else if (lr < -20) bits = ajps_pkg::BRIDGE_LEFT;
			else bits = ajps_pkg::BRIDGE_OFF;
			duty_hold = 8'(80 + slider * 175 / 100);
		end

		// joint jog and gripper
		arm_base = jogged(arm_base, f.base_stick);
		arm_shoulder = jogged(arm_shoulder, f.shoulder_stick);
		arm_elbow = jogged(arm_elbow, f.elbow_stick);
		arm_wrist = jogged(arm_wrist, f.wrist_stick);
		if (f.buttons & BTN_GRAB_M) arm_grip += int'(grip_step_cfg);
		if (f.buttons & BTN_OPEN_M) arm_grip -= int'(grip_step_cfg);

		// sequence starts, drop wins when both pressed
		if ((f.buttons & BTN_PICK_M) && !pick_on) begin
			pick_on = 1'b1;
			drop_on = 1'b0;
			pose_step = 2'd0;
			pose_t0 = f.now_ms;
		end
		if ((f.buttons & BTN_DROP_M) && !drop_on) begin
			drop_on = 1'b1;
			pick_on = 1'b0;
			pose_step = 2'd0;
			pose_t0 = f.now_ms;
		end

		// pick poses
		if (pick_on && pose_due(f.now_ms)) begin
			pose_t0 = f.now_ms;
			case (pose_step)
				2'd0: begin
					arm_shoulder = 120;
					arm_elbow = 60;
					arm_wrist = 80;
				end
				2'd1: begin
					arm_shoulder = 140;
					arm_elbow = 40;
				end
				2'd2: arm_grip = 120;
				default: begin
					arm_shoulder = 90;
					arm_elbow = 90;
					pick_on = 1'b0;
				end
			endcase
			pose_step = pose_step + 2'd1;
		end

		// drop poses
		if (drop_on && pose_due(f.now_ms)) begin
			pose_t0 = f.now_ms;
			case (pose_step)
				2'd0: begin
					arm_shoulder = 110;
					arm_elbow = 60;
					arm_wrist = 70;
					pose_step = 2'd1;
				end
				2'd1: begin
					arm_grip = 30;
					pose_step = 2'd2;
				end
				2'd2: begin
					arm_shoulder = 90;
					arm_elbow = 90;
					drop_on = 1'b0;
					pose_step = 2'd0;
				end
				default: pose_step = 2'd0;
			endcase
		end

		arm_base = clamp_int(arm_base, 0, 180);
		arm_shoulder = clamp_int(arm_shoulder, 30, 150);
		arm_elbow = clamp_int(arm_elbow, 0, 170);
		arm_wrist = clamp_int(arm_wrist, 0, 180);
		arm_grip = clamp_int(arm_grip, 30, 120);

		r.base_angle = 8'(arm_base);
		r.shoulder_angle = 8'(arm_shoulder);
		r.elbow_angle = 8'(arm_elbow);
		r.wrist_angle = 8'(arm_wrist);
		r.grip_angle = 7'(arm_grip);
		r.bridge_bits = bits;
		r.drive_duty = duty_hold;
		r.pick_busy = pick_on;
		r.drop_busy = drop_on;
		return r;
	endfunction

	function automatic ajps_pkg::frame_t mk(int fb, int lr, int b, int s, int e, int w,
			logic [4:0] btn, int slider, logic [31:0] t);
		ajps_pkg::frame_t f;
		f.drive_front_back = 8'(fb);
		f.drive_left_right = 8'(lr);
		f.base_stick = 8'(b);
		f.shoulder_stick = 8'(s);
		f.elbow_stick = 8'(e);
		f.wrist_stick = 8'(w);
		f.buttons = btn;
		f.speed_slider = 7'(slider);
		f.now_ms = t;
		return f;
	endfunction

	// stick value: centered, in range, full code range, or at the dead zone edge
	function automatic int rand_stick();
		int v;
		case ($urandom_range(3))
			0: v = 0;
			1: v = int'($urandom_range(200)) - 100;
			2: v = int'($urandom_range(255)) - 128;
			default: begin
				v = int'(dz_cfg) + int'($urandom_range(1));
				if (v > 127) v = 127;
				if ($urandom_range(1)) v = -v;
			end
		endcase
		return v;
	endfunction

	// random frame with time mostly stepping on the scale of the pose interval
	function automatic ajps_pkg::frame_t rand_frame();
		logic [4:0] btn;
		int         slider;
		btn = 5'd0;
		if ($urandom_range(99) < 30) btn |= BTN_GRAB_M;
		if ($urandom_range(99) < 25) btn |= BTN_OPEN_M;
		if ($urandom_range(99) < 6) btn |= BTN_PICK_M;
		if ($urandom_range(99) < 5) btn |= BTN_DROP_M;
		if ($urandom_range(99) < 20) btn |= BTN_STOP_M;
		slider = ($urandom_range(99) < 85) ? $urandom_range(100) : $urandom_range(127, 101);
		if ($urandom_range(99) < 5)
			sim_ms = $urandom();
		else if (interval_cfg == 16'd0)
			sim_ms += $urandom_range(3);
		else
			sim_ms += $urandom_range(int'(interval_cfg) * 3 / 2);
		return mk(rand_stick(), rand_stick(), rand_stick(), rand_stick(), rand_stick(),
			rand_stick(), btn, slider, sim_ms);
	endfunction

	task automatic check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	// time-zero values on every block input
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ajps_pkg::CFG_DEAD_ZONE;
		cfg_wdata = 16'd0;
		frame_ch.valid = 1'b0;
		frame_ch.drive_front_back = '0;
		frame_ch.drive_left_right = '0;
		frame_ch.base_stick = '0;
		frame_ch.shoulder_stick = '0;
		frame_ch.elbow_stick = '0;
		frame_ch.wrist_stick = '0;
		frame_ch.buttons = '0;
		frame_ch.speed_slider = '0;
		frame_ch.now_ms = '0;
		result_ch.ready = 1'b0;
	end

	// frame driver: predicts on each accepted transaction
	always @(posedge clk) begin
		if (!arst_n) begin
			frame_ch.valid <= 1'b0;
		end else begin
			if (frame_ch.valid && frame_ch.ready) begin
				expected_servo_out.push_back(next_servo_result(on_bus));
				frames_accepted++;
			end
			if (!frame_ch.valid || frame_ch.ready) begin
				if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = frames_to_send.pop_front();
					frame_ch.valid <= 1'b1;
					frame_ch.drive_front_back <= on_bus.drive_front_back;
					frame_ch.drive_left_right <= on_bus.drive_left_right;
					frame_ch.base_stick <= on_bus.base_stick;
					frame_ch.shoulder_stick <= on_bus.shoulder_stick;
					frame_ch.elbow_stick <= on_bus.elbow_stick;
					frame_ch.wrist_stick <= on_bus.wrist_stick;
					frame_ch.buttons <= on_bus.buttons;
					frame_ch.speed_slider <= on_bus.speed_slider;
					frame_ch.now_ms <= on_bus.now_ms;
				end else begin
					frame_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_servo_out.size() == 0) begin
					$error("result transaction with no frame outstanding");
					fail_count++;
				end else begin
					ajps_pkg::result_t e;
					e = expected_servo_out.pop_front();
					check_field("base_angle", e.base_angle, result_ch.base_angle);
					check_field("shoulder_angle", e.shoulder_angle, result_ch.shoulder_angle);
					check_field("elbow_angle", e.elbow_angle, result_ch.elbow_angle);
					check_field("wrist_angle", e.wrist_angle, result_ch.wrist_angle);
					check_field("grip_angle", e.grip_angle, result_ch.grip_angle);
					check_field("bridge_bits", e.bridge_bits, result_ch.bridge_bits);
					check_field("drive_duty", e.drive_duty, result_ch.drive_duty);
					check_field("pick_busy", e.pick_busy, result_ch.pick_busy);
					check_field("drop_busy", e.drop_busy, result_ch.drop_busy);
				end
			end
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic queue_frame(ajps_pkg::frame_t f);
		frames_to_send.push_back(f);
		frames_queued++;
	endtask

	task automatic wait_drained();
		while (frames_accepted != frames_queued || expected_servo_out.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(logic [6:0] dz, logic [15:0] iv, logic [3:0] gs);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ajps_pkg::CFG_DEAD_ZONE;
		cfg_wdata <= {9'd0, dz};
		@(posedge clk);
		cfg_index <= ajps_pkg::CFG_POSE_INTERVAL;
		cfg_wdata <= iv;
		@(posedge clk);
		cfg_index <= ajps_pkg::CFG_GRIP_STEP;
		cfg_wdata <= {12'd0, gs};
		@(posedge clk);
		cfg_we <= 1'b0;
		dz_cfg = dz;
		interval_cfg = iv;
		grip_step_cfg = gs;
	endtask

	task automatic run_batch(logic [6:0] dz, logic [15:0] iv, logic [3:0] gs,
			logic [31:0] start_ms, int tx_idle, int rx_idle);
		wait_drained();
		write_regs(dz, iv, gs);
		send_idle_pct = tx_idle;
		recv_idle_pct = rx_idle;
		sim_ms = start_ms;
		repeat (88) queue_frame(rand_frame());
	endtask

	// stimulus sequence
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drive decode, duty and dead zone edges at reset settings
		queue_frame(mk(0, 0, 0, 0, 0, 0, 5'd0, 0, 32'd0));
		queue_frame(mk(127, 0, 127, 127, 127, 127, 5'd0, 100, 32'd5));
		queue_frame(mk(-128, 0, -128, -128, -128, -128, 5'd0, 127, 32'd10));
		queue_frame(mk(21, -100, 10, -10, 11, -11, 5'd0, 50, 32'd15));
		queue_frame(mk(20, 21, 20, -20, 19, -19, 5'd0, 1, 32'd20));
		queue_frame(mk(-20, -21, 100, -100, 0, 0, 5'd0, 99, 32'd25));
		queue_frame(mk(100, 127, 0, 0, 0, 0, BTN_STOP_M, 0, 32'd30));
		// gripper
		queue_frame(mk(0, 0, 0, 0, 0, 0, BTN_GRAB_M | BTN_OPEN_M, 0, 32'd35));
		queue_frame(mk(0, 0, 0, 0, 0, 0, BTN_GRAB_M, 0, 32'd40));
		queue_frame(mk(0, 0, 0, 0, 0, 0, BTN_GRAB_M, 0, 32'd45));
		queue_frame(mk(0, 0, 0, 0, 0, 0, BTN_OPEN_M, 0, 32'd50));
		// pick and drop together: only drop runs
		queue_frame(mk(0, 0, 0, 0, 0, 0, BTN_PICK_M | BTN_DROP_M, 0, 32'd1000));
		queue_frame(mk(0, 0, 0, 0, 0, 0, 5'd0, 0, 32'd1399));
		queue_frame(mk(0, 0, 0, 0, 0, 0, 5'd0, 0, 32'd1400));
		queue_frame(mk(0, 0, 0, 0, 0, 0, 5'd0, 0, 32'd1800));
		queue_frame(mk(0, 0, 0, 0, 0, 0, 5'd0, 0, 32'd2200));
		// pick, repeated press ignored, then drop cancels it
		queue_frame(mk(0, 0, 0, 0, 0, 0, BTN_PICK_M, 0, 32'd3000));
		queue_frame(mk(0, 0, 0, 0, 0, 0, BTN_PICK_M, 0, 32'd3100));
		queue_frame(mk(0, 0, 0, 0, 0, 0, 5'd0, 0, 32'd3400));
		queue_frame(mk(0, 0, 0, 0, 0, 0, 5'd0, 0, 32'd3800));
		queue_frame(mk(0, 0, 0, 0, 0, 0, BTN_DROP_M, 0, 32'd4000));
		// pick across the timestamp wrap
		queue_frame(mk(0, 0, 0, 0, 0, 0, BTN_PICK_M, 0, 32'hFFFF_FF00));
		queue_frame(mk(0, 0, 0, 0, 0, 0, 5'd0, 0, 32'h0000_008F));
		queue_frame(mk(0, 0, 0, 0, 0, 0, 5'd0, 0, 32'h0000_0090));
		queue_frame(mk(0, 0, 0, 0, 0, 0, 5'h1F, 100, 32'h0000_0100));

		// random frames over several register settings and idle patterns
		run_batch(7'd0, 16'd1, 4'd15, 32'd0, 7, 47);
		run_batch(7'd127, 16'd65535, 4'd0, 32'd12345, 7, 47);
		run_batch(7'd100, 16'd0, 4'd1, 32'd500, 47, 7);
		run_batch(7'd5, 16'd3, 4'd7, 32'hFFFF_FFF0, 47, 7);
		run_batch(7'd20, 16'd10, 4'd4, 32'd77, 0, 0);
		run_batch(7'd10, 16'd400, 4'd2, 32'hFFFF_FE00, 0, 0);

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
